[rtl/core/ycbcr_to_rgb_pixel_converter_macros.svh]
// Assertion macros shared by the pixel converter RTL files.
// Depends on nothing; the files that check their own logic include it.
`ifndef YCBCR_TO_RGB_PIXEL_CONVERTER_MACROS_SVH
`define YCBCR_TO_RGB_PIXEL_CONVERTER_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define YCC2RGB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
// Next-cycle implication, disabled while reset is asserted.
`define YCC2RGB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define YCC2RGB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define YCC2RGB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

[rtl/core/ycc2rgb_pkg.sv]
// Shared types, constants and helpers of the YCbCr to RGB pixel converter.
// Depends on nothing; every RTL module of the converter imports it.
`default_nettype none

package ycc2rgb_pkg;

    localparam int MAX_DIM_DEFAULT = 4096;

    // Widths fixed by the stream and register formats.
    localparam int PIX_W    = 8;
    localparam int CFG_W    = 13;
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 3;
    localparam int SUM_W    = 26;
    localparam int FRAC_BITS = 13;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
    localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);

    // BT.601 studio-range coefficients scaled by 8192 and rounded.
    localparam logic signed [15:0] K_Y   = 16'sd9535;
    localparam logic signed [15:0] K_CRR = 16'sd13074;
    localparam logic signed [15:0] K_CRG = -16'sd6660;
    localparam logic signed [15:0] K_CBG = -16'sd3203;
    localparam logic signed [15:0] K_CBB = 16'sd16531;

    localparam logic signed [9:0] LUMA_OFFSET   = 10'sd16;
    localparam logic signed [9:0] CHROMA_OFFSET = 10'sd128;

    localparam logic signed [SUM_W-1:0] CLAMP_MAX = SUM_W'(255 << FRAC_BITS);

    // Register word index taken from the APB address.
    typedef enum logic [0:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } t_reg_idx;

    // Position flags that travel with each pixel.
    typedef struct packed {
        logic frame_end;
        logic pad_after;
        logic row_end;
    } t_flags;

    // Clamp a scaled sum to 0..255 and drop the fraction bits.
    function automatic logic [PIX_W-1:0] to_byte(input logic signed [SUM_W-1:0] s);
        logic [PIX_W-1:0] res;
        if (s < 0) begin
            res = '0;
        end else if (s > CLAMP_MAX) begin
            res = {PIX_W{1'b1}};
        end else begin
            res = s[FRAC_BITS +: PIX_W];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

[rtl/core/ycbcr_to_rgb_pixel_converter.sv]
// Top level of the YCbCr to RGB pixel converter: stream ports, APB registers,
// two-stage pipeline. Depends on ycc2rgb_pkg, ycc2rgb_pos and ycc2rgb_matrix.
//
// Usage: pixels enter on the slave stream, one transaction per pixel, with Y,
// Cb and Cr bytes packed in tdata. Each pixel leaves on the master stream as
// blue, green and red bytes, converted with BT.601 studio-range coefficients
// in 13-bit fixed point, clamped to 0..255 and truncated. tlast marks the last
// pixel of a row; tuser flags BMP row padding after the pixel and
// the last pixel of the frame. The APB port holds the image width and height,
// which should be written only while no pixel is in flight.
//
// A pixel accepted on the slave side is captured in the input register, passes
// the color matrix and is presented on the master side from the result
// register. Throughput is one pixel per clock while the master side does not
// stall. The input stage refills whenever the result register drains or
// stands empty, so a stall on the master side backs up through tready with no
// transaction lost or repeated.
//
// A synchronous low reset empties both stages, returns the frame position to
// the first pixel and loads a width of 640 and a height of 480.
`default_nettype none

`include "ycbcr_to_rgb_pixel_converter_macros.svh"

module ycbcr_to_rgb_pixel_converter
    import ycc2rgb_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // APB configuration port.
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,
    // Slave stream of YCbCr pixels.
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [23:0]       s_axis_tdata,   // luma, chroma_blue, chroma_red
    // Master stream of RGB pixels.
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic      [23:0]       m_axis_tdata,   // blue, green, red
    output logic                   m_axis_tlast,   // row_end
    output logic      [1:0]        m_axis_tuser    // pad_after, frame_end
);

    logic [CFG_W-1:0] r_width;
    logic [CFG_W-1:0] r_height;

    logic             r_s1_valid;
    logic [23:0]      r_s1_pix;
    t_flags           r_s1_flags;
    logic             r_out_valid;
    logic [23:0]      r_out_pix;
    t_flags           r_out_flags;

    logic             s_accept;
    logic             out_en;
    logic             s1_en;
    logic             cfg_write;
    t_reg_idx         reg_idx;
    t_flags           pos_flags;
    logic [PIX_W-1:0] mat_blue;
    logic [PIX_W-1:0] mat_green;
    logic [PIX_W-1:0] mat_red;

    // ---------------------------------------------------------------
    // Configuration registers. Words are decoded on address bit 2 only.
    // ---------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_idx   = t_reg_idx'(paddr[2]);

    always_comb begin
        case (reg_idx)
            REG_IMAGE_WIDTH:  prdata = APB_DW'(r_width);
            REG_IMAGE_HEIGHT: prdata = APB_DW'(r_height);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
        end else if (cfg_write) begin
            case (reg_idx)
                REG_IMAGE_WIDTH:  r_width  <= pwdata[CFG_W-1:0];
                REG_IMAGE_HEIGHT: r_height <= pwdata[CFG_W-1:0];
                default:          r_width  <= r_width;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Pipeline control. The result register moves when it is empty or
    // being taken; the input stage moves when it is empty or can hand on.
    // ---------------------------------------------------------------
    assign out_en        = !r_out_valid || m_axis_tready;
    assign s1_en         = !r_s1_valid || out_en;
    assign s_axis_tready = s1_en;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    // Frame position is sampled when the pixel is accepted.
    ycc2rgb_pos #(
        .MAX_DIM (MAX_DIM)
    ) u_pos (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (s_accept),
        .i_width  (r_width),
        .i_height (r_height),
        .o_flags  (pos_flags)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_en) begin
                r_s1_valid <= s_axis_tvalid;
            end
            if (out_en) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_s1_pix   <= s_axis_tdata;
            r_s1_flags <= pos_flags;
        end
    end

    // Color matrix between the input register and the result register.
    ycc2rgb_matrix u_matrix (
        .i_luma        (r_s1_pix[7:0]),
        .i_chroma_blue (r_s1_pix[15:8]),
        .i_chroma_red  (r_s1_pix[23:16]),
        .o_blue        (mat_blue),
        .o_green       (mat_green),
        .o_red         (mat_red)
    );

    always_ff @(posedge i_clk) begin
        if (out_en && r_s1_valid) begin
            r_out_pix   <= {mat_red, mat_green, mat_blue};
            r_out_flags <= r_s1_flags;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_pix;
    assign m_axis_tlast  = r_out_flags.row_end;
    assign m_axis_tuser  = {r_out_flags.frame_end, r_out_flags.pad_after};

    // A frame end or a padding flag only ever comes on the last pixel of a row,
    // and a pixel held in the input stage is never dropped while stalled.
    `YCC2RGB_ASSERT_IMPL(a_frame_last, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[1], m_axis_tlast)
    `YCC2RGB_ASSERT_IMPL(a_pad_last, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[0], m_axis_tlast)
    `YCC2RGB_ASSERT_NEXT(a_s1_held_on_stall, i_clk, i_rst_n, r_s1_valid && !out_en, r_s1_valid)

endmodule

`default_nettype wire

[rtl/core/ycc2rgb_matrix.sv]
// Fixed-point BT.601 color matrix: one YCbCr pixel to clamped B, G, R bytes.
// Depends on ycc2rgb_pkg for coefficients and the clamp helper.
`default_nettype none

module ycc2rgb_matrix
    import ycc2rgb_pkg::*;
(
    input  wire logic [PIX_W-1:0] i_luma,
    input  wire logic [PIX_W-1:0] i_chroma_blue,
    input  wire logic [PIX_W-1:0] i_chroma_red,
    output logic      [PIX_W-1:0] o_blue,
    output logic      [PIX_W-1:0] o_green,
    output logic      [PIX_W-1:0] o_red
);

    logic signed [9:0]       y_c;
    logic signed [9:0]       cb_c;
    logic signed [9:0]       cr_c;
    logic signed [SUM_W-1:0] p_y;
    logic signed [SUM_W-1:0] p_cbb;
    logic signed [SUM_W-1:0] p_cbg;
    logic signed [SUM_W-1:0] p_crg;
    logic signed [SUM_W-1:0] p_crr;

    // Remove the studio-range offsets.
    assign y_c  = $signed({2'b00, i_luma}) - LUMA_OFFSET;
    assign cb_c = $signed({2'b00, i_chroma_blue}) - CHROMA_OFFSET;
    assign cr_c = $signed({2'b00, i_chroma_red}) - CHROMA_OFFSET;

    assign p_y   = SUM_W'(K_Y)   * SUM_W'(y_c);
    assign p_cbb = SUM_W'(K_CBB) * SUM_W'(cb_c);
    assign p_cbg = SUM_W'(K_CBG) * SUM_W'(cb_c);
    assign p_crg = SUM_W'(K_CRG) * SUM_W'(cr_c);
    assign p_crr = SUM_W'(K_CRR) * SUM_W'(cr_c);

    assign o_blue  = to_byte(p_y + p_cbb);
    assign o_green = to_byte(p_y + p_crg + p_cbg);
    assign o_red   = to_byte(p_y + p_crr);

endmodule

`default_nettype wire

[rtl/core/ycc2rgb_pos.sv]
// Column and row counters that flag row end, BMP row padding and frame end.
// Depends on ycc2rgb_pkg and the shared assertion macro header.
`default_nettype none

`include "ycbcr_to_rgb_pixel_converter_macros.svh"

module ycc2rgb_pos
    import ycc2rgb_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_step,
    input  wire logic [CFG_W-1:0] i_width,
    input  wire logic [CFG_W-1:0] i_height,
    output t_flags                o_flags
);

    localparam int CNT_W = $clog2(MAX_DIM);
    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int EXT_W = (DIM_W > CFG_W) ? DIM_W : CFG_W;

    logic [CNT_W-1:0] r_col;
    logic [CNT_W-1:0] r_row;
    logic [CNT_W-1:0] n_col;
    logic [CNT_W-1:0] n_row;
    logic [EXT_W-1:0] w_eff;
    logic [EXT_W-1:0] h_eff;

    // Zero counts as one, anything above the maximum saturates.
    function automatic logic [EXT_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
        logic [EXT_W-1:0] ve;
        logic [EXT_W-1:0] res;
        ve = EXT_W'(v);
        if (ve == '0) begin
            res = EXT_W'(1);
        end else if (ve > EXT_W'(MAX_DIM)) begin
            res = EXT_W'(MAX_DIM);
        end else begin
            res = ve;
        end
        return res;
    endfunction

    assign w_eff = eff_dim(i_width);
    assign h_eff = eff_dim(i_height);

    always_comb begin
        o_flags.row_end   = ({1'b0, EXT_W'(r_col)} + (EXT_W+1)'(1)) >= {1'b0, w_eff};
        o_flags.frame_end = o_flags.row_end
                            && (({1'b0, EXT_W'(r_row)} + (EXT_W+1)'(1)) >= {1'b0, h_eff});
        o_flags.pad_after = o_flags.row_end && (w_eff[1:0] != 2'b00);
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_step) begin
            if (o_flags.frame_end) begin
                n_col = '0;
                n_row = '0;
            end else if (o_flags.row_end) begin
                n_col = '0;
                n_row = r_row + CNT_W'(1);
            end else begin
                n_col = r_col + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    `YCC2RGB_ASSERT_NEXT(a_row_end_clears_col, i_clk, i_rst_n, i_step && o_flags.row_end, r_col == '0)
    `YCC2RGB_ASSERT_NEXT(a_frame_end_clears_all, i_clk, i_rst_n, i_step && o_flags.frame_end, (r_col == '0) && (r_row == '0))
    `YCC2RGB_ASSERT_NEXT(a_col_advances, i_clk, i_rst_n, i_step && !o_flags.row_end, r_col == $past(r_col) + CNT_W'(1))

endmodule

`default_nettype wire

[sim/ycbcr_to_rgb_pixel_converter_test.sv]
// Self-checking testbench for the YCbCr to RGB pixel converter: stream traffic,
// APB register writes and readback, checked against a fixed-point predictor.
// Depends on ycc2rgb_pkg and the ycbcr_to_rgb_pixel_converter RTL.
`timescale 1ns / 1ps

module ycbcr_to_rgb_pixel_converter_test;
    import ycc2rgb_pkg::*;

    localparam int CYCLE_LIMIT   = 200_000;
    localparam int RANDOM_PIXELS = 1950;
    localparam int IDLE_PERCENT  = 11;
    localparam int DIM_LIMIT     = 4096;

    // BT.601 studio-range coefficients, scaled by 8192 and rounded.
    localparam int COEF_Y     = 9535;
    localparam int COEF_CR_R  = 13074;
    localparam int COEF_CR_G  = -6660;
    localparam int COEF_CB_G  = -3203;
    localparam int COEF_CB_B  = 16531;
    localparam int SCALE_BITS = 13;

    // One converted pixel as it should leave the master stream.
    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic       row_end;
        logic       pad_after;
        logic       frame_end;
    } t_rgb_pixel;

    // One row of the directed stimulus. When known is set, the color bytes
    // are typed in; the position flags always come from the predictor.
    typedef struct packed {
        logic       known;
        logic [7:0] luma;
        logic [7:0] chroma_blue;
        logic [7:0] chroma_red;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_directed_row;

    // A scripted register setting and the number of pixels sent under it.
    typedef struct packed {
        logic [31:0] width;
        logic [31:0] height;
        logic [15:0] pixels;
    } t_frame_setting;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [23:0]       s_axis_tdata = '0;   // luma, chroma_blue, chroma_red
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [23:0]       m_axis_tdata;        // blue, green, red
    logic              m_axis_tlast;        // row_end
    logic [1:0]        m_axis_tuser;        // pad_after, frame_end

    // Predictor state: the register contents and the frame position.
    logic [CFG_W-1:0] width_shadow = 13'd640;
    logic [CFG_W-1:0] height_shadow = 13'd480;
    int               column_pos = 0;
    int               row_pos = 0;

    t_rgb_pixel rgb_pending [$];
    int         fail_count = 0;
    int         cycle_count = 0;
    int         pixels_sent = 0;
    // While set, neither side of the stream idles.
    bit         steady = 1'b0;

    // Extremes of every field, all-zero and all-one chroma, the black and
    // white points of studio range and a few patterns that flip every bit.
    t_directed_row directed_rows [24] = '{
        '{1'b1, 8'd16,  8'd128, 8'd128, 8'd0,   8'd0,   8'd0},
        '{1'b1, 8'd235, 8'd128, 8'd128, 8'd254, 8'd254, 8'd254},
        '{1'b1, 8'd0,   8'd128, 8'd128, 8'd0,   8'd0,   8'd0},
        '{1'b1, 8'd255, 8'd128, 8'd128, 8'd255, 8'd255, 8'd255},
        '{1'b1, 8'd0,   8'd0,   8'd0,   8'd0,   8'd135, 8'd0},
        '{1'b1, 8'd255, 8'd255, 8'd255, 8'd255, 8'd125, 8'd255},
        '{1'b0, 8'd255, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0},
        '{1'b0, 8'd0,   8'd255, 8'd255, 8'd0,   8'd0,   8'd0},
        '{1'b0, 8'd255, 8'd0,   8'd255, 8'd0,   8'd0,   8'd0},
        '{1'b0, 8'd255, 8'd255, 8'd0,   8'd0,   8'd0,   8'd0},
        '{1'b0, 8'd0,   8'd255, 8'd0,   8'd0,   8'd0,   8'd0},
        '{1'b0, 8'd0,   8'd0,   8'd255, 8'd0,   8'd0,   8'd0},
        '{1'b0, 8'd16,  8'd240, 8'd16,  8'd0,   8'd0,   8'd0},
        '{1'b0, 8'd16,  8'd16,  8'd240, 8'd0,   8'd0,   8'd0},
        '{1'b0, 8'd235, 8'd16,  8'd240, 8'd0,   8'd0,   8'd0},
        '{1'b0, 8'd235, 8'd240, 8'd16,  8'd0,   8'd0,   8'd0},
        '{1'b0, 8'd128, 8'd128, 8'd128, 8'd0,   8'd0,   8'd0},
        '{1'b0, 8'd170, 8'd85,  8'd170, 8'd0,   8'd0,   8'd0},
        '{1'b0, 8'd85,  8'd170, 8'd85,  8'd0,   8'd0,   8'd0},
        '{1'b0, 8'd1,   8'd2,   8'd4,   8'd0,   8'd0,   8'd0},
        '{1'b0, 8'd254, 8'd253, 8'd251, 8'd0,   8'd0,   8'd0},
        '{1'b0, 8'd81,  8'd90,  8'd240, 8'd0,   8'd0,   8'd0},
        '{1'b0, 8'd145, 8'd54,  8'd34,  8'd0,   8'd0,   8'd0},
        '{1'b0, 8'd41,  8'd240, 8'd110, 8'd0,   8'd0,   8'd0}
    };

    // Scripted settings walk through the corners of the dimension handling:
    // zero (treated as one), a width that is a multiple of four, odd sizes,
    // upper pwdata bits that the register drops, the largest legal size,
    // values above it that saturate, and a width that shrinks below the
    // current column so that the next pixel must close the row.
    t_frame_setting scripted_settings [10] = '{
        '{32'd0,        32'd0,        16'd6},
        '{32'd4,        32'd2,        16'd20},
        '{32'd3,        32'd3,        16'd20},
        '{32'd5,        32'h0001_2003, 16'd25},
        '{32'd4096,     32'd4096,     16'd150},
        '{32'd8191,     32'd8191,     16'd10},
        '{32'd7,        32'd2,        16'd20},
        '{32'd4097,     32'd1,        16'd30},
        '{32'd2,        32'd4096,     16'd30},
        '{32'd1,        32'd3,        16'd12}
    };

    ycbcr_to_rgb_pixel_converter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // A register value of zero acts as one, anything above the largest
    // supported size acts as that size.
    function automatic int fit_dim(logic [CFG_W-1:0] value);
        if (value == 0) begin
            return 1;
        end
        if (value > DIM_LIMIT) begin
            return DIM_LIMIT;
        end
        return int'(value);
    endfunction

    // Clamp a scaled sum to 0..255 and drop the fraction.
    function automatic logic [7:0] saturate_byte(int sum);
        if (sum < 0) begin
            return 8'd0;
        end
        if (sum > (255 << SCALE_BITS)) begin
            return 8'd255;
        end
        return 8'(sum >>> SCALE_BITS);
    endfunction

    // Converts one pixel and advances the frame position, exactly as the
    // block does for each accepted input transaction.
    function automatic t_rgb_pixel convert_pixel(logic [7:0] luma, logic [7:0] chroma_blue,
                                                 logic [7:0] chroma_red);
        t_rgb_pixel px;
        int         luma_term;
        int         cb;
        int         cr;
        int         cols;
        int         rows;
        luma_term = COEF_Y * (int'(luma) - 16);
        cb = int'(chroma_blue) - 128;
        cr = int'(chroma_red) - 128;
        cols = fit_dim(width_shadow);
        rows = fit_dim(height_shadow);
        px.blue = saturate_byte(luma_term + COEF_CB_B * cb);
        px.green = saturate_byte(luma_term + COEF_CR_G * cr + COEF_CB_G * cb);
        px.red = saturate_byte(luma_term + COEF_CR_R * cr);
        // A counter that already sits at or past the last position closes
        // the row (or frame) with this pixel, which covers shrinking sizes.
        px.row_end = (column_pos + 1 >= cols);
        px.frame_end = px.row_end && (row_pos + 1 >= rows);
        px.pad_after = px.row_end && (cols % 4 != 0);
        if (px.frame_end) begin
            column_pos = 0;
            row_pos = 0;
        end else if (px.row_end) begin
            column_pos = 0;
            row_pos++;
        end else begin
            column_pos++;
        end
        return px;
    endfunction

    function automatic bit idle_now();
        return !steady && ($urandom_range(99) < IDLE_PERCENT);
    endfunction

    // Mostly uniform samples, with the field corners and the studio-range
    // limits drawn more often than chance would give.
    function automatic logic [7:0] pick_sample();
        if ($urandom_range(7) != 0) begin
            return 8'($urandom_range(255));
        end
        case ($urandom_range(5))
            0: return 8'd0;
            1: return 8'd16;
            2: return 8'd128;
            3: return 8'd235;
            4: return 8'd240;
            default: return 8'd255;
        endcase
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // One APB transaction: a setup phase, then an access phase that completes
    // at the edge where pready is seen high, then psel is driven low again.
    task automatic apb_access(t_reg_idx idx, bit is_write, logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= is_write;
        paddr <= APB_AW'(4 * int'(idx));
        pwdata <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic verify_register(t_reg_idx idx);
        logic [31:0] readback;
        apb_access(idx, 1'b0, 32'd0, readback);
        if (idx == REG_IMAGE_WIDTH) begin
            check_field("image_width", int'(width_shadow), int'(readback));
        end else begin
            check_field("image_height", int'(height_shadow), int'(readback));
        end
    endtask

    // Writes a register, keeps the predictor's copy in step, reads it back.
    task automatic write_register(t_reg_idx idx, logic [31:0] value);
        logic [31:0] unused;
        apb_access(idx, 1'b1, value, unused);
        if (idx == REG_IMAGE_WIDTH) begin
            width_shadow = value[CFG_W-1:0];
        end else begin
            height_shadow = value[CFG_W-1:0];
        end
        verify_register(idx);
    endtask

    task automatic set_frame_size(logic [31:0] width, logic [31:0] height);
        write_register(REG_IMAGE_WIDTH, width);
        write_register(REG_IMAGE_HEIGHT, height);
    endtask

    // Offers one pixel on the slave stream, possibly after a random gap, and
    // records the expected result once the transaction is accepted. tvalid
    // stays high on return so that back-to-back pixels leave no gap on the stream.
    task automatic send_pixel(t_directed_row row);
        t_rgb_pixel want;
        if (idle_now()) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while (idle_now());
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {row.chroma_red, row.chroma_blue, row.luma};
        do @(posedge i_clk); while (!s_axis_tready);
        want = convert_pixel(row.luma, row.chroma_blue, row.chroma_red);
        if (row.known) begin
            want.blue = row.blue;
            want.green = row.green;
            want.red = row.red;
        end
        rgb_pending.push_back(want);
    endtask

    task automatic send_random_pixels(int count);
        t_directed_row row;
        repeat (count) begin
            row = '0;
            row.luma = pick_sample();
            row.chroma_blue = pick_sample();
            row.chroma_red = pick_sample();
            send_pixel(row);
            pixels_sent++;
        end
    endtask

    // Stops offering pixels and waits until every expected result has left
    // the block, so that the registers can be written safely.
    task automatic drain_pipeline();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (rgb_pending.size() != 0);
    endtask

    // Receiver: stalls at random and checks every output transaction against
    // the oldest pending expectation. Sampling right after the edge sees the
    // values that were present at the edge.
    always @(posedge i_clk) begin
        t_rgb_pixel want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (rgb_pending.size() == 0) begin
                $error("output transaction with no pixel pending: tdata %h", m_axis_tdata);
                fail_count++;
            end else begin
                want = rgb_pending.pop_front();
                check_field("blue", want.blue, m_axis_tdata[7:0]);
                check_field("green", want.green, m_axis_tdata[15:8]);
                check_field("red", want.red, m_axis_tdata[23:16]);
                check_field("row_end", want.row_end, m_axis_tlast);
                check_field("pad_after", want.pad_after, m_axis_tuser[0]);
                check_field("frame_end", want.frame_end, m_axis_tuser[1]);
            end
        end
        m_axis_tready <= !idle_now();
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("ycbcr_to_rgb_pixel_converter_test NOT OK");
            $finish;
        end
    end

    initial begin
        logic [31:0] width;
        logic [31:0] height;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The registers must come out of reset as 640 by 480.
        verify_register(REG_IMAGE_WIDTH);
        verify_register(REG_IMAGE_HEIGHT);

        // Directed pixels run under the reset size, which also checks that
        // the frame position starts at the first pixel.
        foreach (directed_rows[i]) begin
            send_pixel(directed_rows[i]);
        end
        drain_pipeline();

        // The frame position carries over between settings, so each new
        // size also acts as a change in the middle of a frame.
        foreach (scripted_settings[i]) begin
            set_frame_size(scripted_settings[i].width, scripted_settings[i].height);
            send_random_pixels(int'(scripted_settings[i].pixels));
            drain_pipeline();
        end

        // Random settings lean toward small frames, where row and frame ends
        // come often; now and then a full-range or saturating size is chosen.
        while (pixels_sent < RANDOM_PIXELS) begin
            case ($urandom_range(9))
                0: begin
                    width = $urandom_range(0, 8191);
                    height = $urandom_range(0, 8191);
                end
                1: begin
                    width = $urandom_range(1, DIM_LIMIT);
                    height = $urandom_range(1, 6);
                end
                2: begin
                    width = $urandom_range(1) ? 32'd0 : $urandom_range(DIM_LIMIT, 8191);
                    height = $urandom_range(1, 3);
                end
                3: begin
                    // Upper pwdata bits are outside the register and dropped.
                    width = ($urandom & 32'hFFFF_E000) | $urandom_range(1, 9);
                    height = ($urandom & 32'hFFFF_E000) | $urandom_range(1, 4);
                end
                default: begin
                    width = $urandom_range(1, 9);
                    height = $urandom_range(1, 4);
                end
            endcase
            set_frame_size(width, height);
            // A long stretch in the middle of the run goes without any idling.
            steady = (pixels_sent >= 700) && (pixels_sent < 1050);
            send_random_pixels($urandom_range(20, 120));
            drain_pipeline();
        end
        steady = 1'b0;

        // Give the pipeline time to show any stray output.
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("ycbcr_to_rgb_pixel_converter_test OK");
        end else begin
            $display("ycbcr_to_rgb_pixel_converter_test NOT OK");
        end
        $finish;
    end

endmodule
